[sv/multi_channel_event_timer_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-channel event timer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_EVENT_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_EVENT_TIMER_DEFINES_SVH

// Overlapping implication, disabled while reset is high.
`define MCET_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcet assertion failed");

// Implication into the following cycle, disabled while reset is high.
`define MCET_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcet assertion failed");

// Implication into the following cycle that also holds across reset.
`define MCET_ASSERT_ALWAYS_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mcet assertion failed");

`endif

[sv/mcet_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel event timer package
// Payload types, action codes and the sequencer's control store.
// ----------------------------------------------------------------------------
package mcet_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int STEP_W      = 3;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic EVT_CYCLE   = 1'b0;
  localparam logic EVT_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  timer_id;
    logic [15:0] duration;
    logic [15:0] cycle_period;
    logic [1:0]  priority_req;
    logic [3:0]  view_tag;
    logic        with_events;
  } cmd_t;

  typedef struct packed {
    logic       event_kind;
    logic [1:0] event_timer;
    logic [3:0] event_view;
    logic       last;
  } evt_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FETCH = 3'd0;
  localparam step_t STEP_TICK  = 3'd1;
  localparam step_t STEP_SCAN  = 3'd2;
  localparam step_t STEP_FLUSH = 3'd3;
  localparam step_t STEP_START = 3'd4;
  localparam step_t STEP_STOP  = 3'd5;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_TICK,
    OP_SCAN,
    OP_FLUSH,
    OP_START,
    OP_STOP
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_JUMP,
    COND_SCAN_END,
    COND_DISPATCH
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Control store: one word per program step.
  function automatic ucode_t mcet_ucode(input step_t step);
    ucode_t w;
    unique case (step)
      STEP_FETCH: w = '{op: OP_FETCH, cond: COND_DISPATCH, target: STEP_FETCH};
      STEP_TICK:  w = '{op: OP_TICK,  cond: COND_NEXT,     target: STEP_SCAN};
      STEP_SCAN:  w = '{op: OP_SCAN,  cond: COND_SCAN_END, target: STEP_FLUSH};
      STEP_FLUSH: w = '{op: OP_FLUSH, cond: COND_JUMP,     target: STEP_FETCH};
      STEP_START: w = '{op: OP_START, cond: COND_JUMP,     target: STEP_FETCH};
      STEP_STOP:  w = '{op: OP_STOP,  cond: COND_JUMP,     target: STEP_FLUSH};
      default:    w = '{op: OP_FETCH, cond: COND_JUMP,     target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

[sv/multi_channel_event_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel event timer
// Millisecond clock with NUM_TIMERS periodic / timeout channels, run by a
// small microcoded sequencer over a single shared channel datapath.
// ----------------------------------------------------------------------------
// Usage: commands arrive on cmd (cmd_valid / cmd_ready): a tick advances the
// clock one millisecond, a start arms a channel, a stop clears one. Events
// leave on evt (evt_valid / evt_ready), one per transfer, with last set on
// the final event a command causes. Starts and ticks with nothing due give
// no event.
// Timing: a start runs fetch then start, a stop fetch, stop and flush, a
// tick fetch, tick, scan and flush. The scan step visits one channel per
// cycle through the shared compare/add unit unless the output stalls it.
// Events are held in a one-entry pending slot plus the output register, so a
// stalled receiver holds the scan or flush step until the output frees; no
// event is lost to a stall. cmd_ready is high only in the fetch step, which
// may run while the last event still waits in the output register. Reset
// clears the clock, all channels and the output register.
// ----------------------------------------------------------------------------
module multi_channel_event_timer #(
  parameter int NUM_TIMERS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  mcet_pkg::cmd_t cmd,
  output logic          evt_valid,
  input  logic          evt_ready,
  output mcet_pkg::evt_t evt
);
  import mcet_pkg::*;

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Sequencer.
  step_t          step;
  step_t          step_next;
  ucode_t         uc;
  logic           hold;

  // Channel state.
  logic [31:0]    cur_time;
  logic [31:0]    expiry_time     [NUM_TIMERS];
  logic           expiry_armed    [NUM_TIMERS];
  logic [31:0]    next_event_time [NUM_TIMERS];
  logic [15:0]    period          [NUM_TIMERS];
  logic [1:0]     stored_priority [NUM_TIMERS];
  logic [3:0]     stored_view     [NUM_TIMERS];

  // Working registers.
  cmd_t           cmd_q;
  logic [IW-1:0]  idx;
  logic [CNT_W-1:0] cnt;
  logic           pend_valid;
  evt_t           pend;

  // Datapath signals.
  logic [IW-1:0]  id_idx;
  logic           id_ok;
  logic           prio_ok;
  logic [15:0]    first_p;
  logic [15:0]    start_p;
  logic           scan_due;
  logic           scan_exp;
  logic           scan_emit;
  logic           scan_end;
  logic           out_free;
  logic           push;
  logic           pend_load;
  logic           pend_clear;
  evt_t           pend_new;

  assign uc        = mcet_ucode(step);
  assign cmd_ready = (uc.op == OP_FETCH);
  assign out_free  = !evt_valid || evt_ready;

  assign id_idx  = IW'(cmd_q.timer_id);
  assign id_ok   = (32'(cmd_q.timer_id) < 32'(NUM_TIMERS));
  assign prio_ok = !(stored_priority[id_idx] > cmd_q.priority_req);

  always_comb begin
    first_p = (cmd_q.cycle_period != 16'd0) ? cmd_q.cycle_period : cmd_q.duration;
    if (cmd_q.duration == 16'd0) begin
      start_p = cmd_q.cycle_period;
    end else begin
      start_p = (first_p < cmd_q.duration) ? first_p : cmd_q.duration;
    end
  end

  assign scan_due  = (period[idx] != 16'd0) && (next_event_time[idx] == cur_time);
  assign scan_exp  = expiry_armed[idx] && (expiry_time[idx] == cur_time);
  assign scan_emit = scan_due && (cnt < CNT_W'(MAX_RESULTS));
  assign scan_end  = (idx == IW'(NUM_TIMERS - 1));

  // Decode of the current control word into datapath strobes.
  always_comb begin
    hold       = 1'b0;
    push       = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    pend_new   = '{event_kind: scan_exp, event_timer: 2'(idx),
                   event_view: stored_view[idx], last: 1'b0};
    unique case (uc.op)
      OP_FETCH: begin
        hold = !cmd_valid;
      end
      OP_SCAN: begin
        if (scan_emit) begin
          hold      = pend_valid && !out_free;
          push      = pend_valid && out_free;
          pend_load = !hold;
        end
      end
      OP_FLUSH: begin
        hold       = pend_valid && !out_free;
        push       = pend_valid && out_free;
        pend_clear = push;
      end
      OP_STOP: begin
        pend_load = id_ok && cmd_q.with_events;
        pend_new  = '{event_kind: EVT_TIMEOUT, event_timer: cmd_q.timer_id,
                      event_view: stored_view[id_idx], last: 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Next step.
  always_comb begin
    step_next = step;
    if (!hold) begin
      unique case (uc.cond)
        COND_NEXT:     step_next = step + 1'b1;
        COND_JUMP:     step_next = uc.target;
        COND_SCAN_END: step_next = scan_end ? uc.target : step;
        COND_DISPATCH: begin
          case (cmd.action)
            ACT_TICK:  step_next = STEP_TICK;
            ACT_START: step_next = STEP_START;
            ACT_STOP:  step_next = STEP_STOP;
            default:   step_next = STEP_FETCH;
          endcase
        end
        default:       step_next = STEP_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= STEP_FETCH;
      evt_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cur_time   <= '0;
      idx        <= '0;
      cnt        <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        expiry_time[i]     <= '0;
        expiry_armed[i]    <= 1'b0;
        next_event_time[i] <= '0;
        period[i]          <= '0;
        stored_priority[i] <= '0;
        stored_view[i]     <= '0;
      end
    end else begin
      step <= step_next;

      if (push) begin
        evt_valid <= 1'b1;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end

      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end

      unique case (uc.op)
        OP_TICK: begin
          cur_time <= cur_time + 32'd1;
          idx      <= '0;
          cnt      <= '0;
        end
        OP_SCAN: begin
          if (!hold) begin
            idx <= idx + 1'b1;
            if (scan_emit) begin
              cnt <= cnt + 1'b1;
            end
            if (scan_due && scan_exp) begin
              expiry_time[idx]     <= '0;
              expiry_armed[idx]    <= 1'b0;
              next_event_time[idx] <= '0;
              period[idx]          <= '0;
              stored_priority[idx] <= '0;
            end else if (scan_due) begin
              next_event_time[idx] <= next_event_time[idx] + 32'(period[idx]);
            end
          end
        end
        OP_START: begin
          if (id_ok && prio_ok) begin
            stored_view[id_idx]     <= cmd_q.view_tag;
            expiry_armed[id_idx]    <= (cmd_q.duration != 16'd0);
            expiry_time[id_idx]     <= (cmd_q.duration != 16'd0) ?
                                       cur_time + 32'(cmd_q.duration) : 32'd0;
            period[id_idx]          <= start_p;
            next_event_time[id_idx] <= cur_time + 32'(start_p);
            stored_priority[id_idx] <= cmd_q.priority_req;
          end
        end
        OP_STOP: begin
          if (id_ok) begin
            expiry_time[id_idx]     <= '0;
            expiry_armed[id_idx]    <= 1'b0;
            next_event_time[id_idx] <= '0;
            period[id_idx]          <= '0;
            stored_priority[id_idx] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
    if (pend_load) begin
      pend <= pend_new;
    end
    if (push) begin
      evt <= '{event_kind: pend.event_kind, event_timer: pend.event_timer,
               event_view: pend.event_view, last: (uc.op == OP_FLUSH)};
    end
  end

endmodule

[sv/mcet_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel event timer port checker
// Watches the command and event channels of the top level over time.
// ----------------------------------------------------------------------------
`include "multi_channel_event_timer_defines.svh"

module mcet_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input mcet_pkg::cmd_t cmd,
  input logic           evt_valid,
  input logic           evt_ready,
  input mcet_pkg::evt_t evt
);
  import mcet_pkg::*;

  // A stalled event holds until its transfer.
  `MCET_ASSERT_NEXT(a_evt_hold, evt_valid && !evt_ready, evt_valid && $stable(evt))

  // Reset empties the output register.
  `MCET_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !evt_valid)

  // Any real command keeps the block busy for at least the next cycle.
  `MCET_ASSERT_NEXT(a_busy_after_cmd,
      cmd_valid && cmd_ready &&
      (cmd.action == ACT_TICK || cmd.action == ACT_START || cmd.action == ACT_STOP),
      !cmd_ready)

  // A new event never appears right after a command transfer.
  `MCET_ASSERT_NEXT(a_no_early_event, cmd_valid && cmd_ready, !$rose(evt_valid))

endmodule

bind multi_channel_event_timer mcet_checker u_mcet_checker (.*);
